[design/assert_macros.svh]
// assertion macros shared by the integer to base string unit
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ITOB_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("itob assertion failed");

// condition must hold in the cycle after the trigger
`define ITOB_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("itob assertion failed");

`endif

[design/itob_pkg.sv]
// types, constants and helper functions of the integer to base string unit
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package itob_pkg;

  localparam int STEP_BITS = 8;   // dividend bits consumed per divider cycle
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // register index taken from paddr[2]
  localparam logic REG_RADIX = 1'b0;

  typedef struct packed {
    logic load;       // capture input value
    logic div_step;   // one divider cycle
    logic div_last;   // last divider cycle of a digit
    logic rd;         // read digit buffer
    logic put_sign;
    logic put_digit;
    logic put_empty;
  } itob_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic negative;
    logic quot_zero;
    logic last_digit;
    logic slot_free;
  } itob_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else begin
      digit_char = CHAR_UPPER + ext - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

[design/itob_ctrl.sv]
// controller state machine: sequences load, division per digit and emission
// depends on itob_pkg for the command and status structs
`default_nettype none

module itob_ctrl #(
  parameter int DIV_CYCLES = 4
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  itob_pkg::itob_stat_t   st,
  output itob_pkg::itob_cmd_t    cmd
);
  import itob_pkg::*;

  localparam int CYC_W = $clog2(DIV_CYCLES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EMPTY = 6'b000010,
    S_SIGN  = 6'b000100,
    S_DIV   = 6'b001000,
    S_READ  = 6'b010000,
    S_PUT   = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CYC_W-1:0] cyc, cyc_next;
  logic             cyc_last;

  assign cyc_last = (cyc == CYC_W'(DIV_CYCLES - 1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cyc_next   = cyc;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = st.radix_ok;
          state_next = st.radix_ok ? S_SIGN : S_EMPTY;
        end
      end
      S_EMPTY: begin
        if (st.slot_free) begin
          cmd.put_empty = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SIGN: begin
        cyc_next = '0;
        if (!st.negative) begin
          state_next = S_DIV;
        end else if (st.slot_free) begin
          cmd.put_sign = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cyc_last) begin
          cmd.div_last = 1'b1;
          cyc_next     = '0;
          if (st.quot_zero) begin
            state_next = S_READ;
          end
        end else begin
          cyc_next = cyc + 1'b1;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_PUT;
      end
      S_PUT: begin
        if (st.slot_free) begin
          cmd.put_digit = 1'b1;
          state_next    = st.last_digit ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cyc   <= '0;
    end else begin
      state <= state_next;
      cyc   <= cyc_next;
    end
  end

endmodule

`default_nettype wire

[design/itob_dp.sv]
// datapath: magnitude, radix divider, digit buffer and output register
// depends on itob_pkg for constants, structs and the digit character function
`default_nettype none

module itob_dp #(
  parameter int VALUE_BITS = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  itob_pkg::itob_cmd_t                   cmd,
  input  wire signed [VALUE_BITS-1:0]           value,
  input  wire        [itob_pkg::RADIX_W-1:0]    radix,
  output itob_pkg::itob_stat_t                  st,
  output logic       [itob_pkg::CHAR_W-1:0]     char_code,
  output logic                                  is_empty,
  output logic                                  is_final,
  output logic                                  out_valid,
  input  wire                                   out_ready
);
  import itob_pkg::*;

  localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS   = DIV_CYCLES * STEP_BITS;
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] raw, mag;
  logic                  neg;
  logic [PAD_BITS-1:0]   w, w_next, w_t;
  logic [DIGIT_W-1:0]    r, r_next, r_t;
  logic [RADIX_W-1:0]    rr;
  logic [CNT_W-1:0]      count, cnt_dec;
  logic [DIGIT_W-1:0]    mem [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_data;

  assign raw     = unsigned'(value);
  assign mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign cnt_dec = count - 1'b1;

  // restoring division, STEP_BITS quotient bits per cycle
  always_comb begin
    w_t = w;
    r_t = r;
    rr  = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      rr  = {r_t, w_t[PAD_BITS-1]};
      w_t = {w_t[PAD_BITS-2:0], 1'b0};
      if (rr >= radix) begin
        rr     = rr - radix;
        w_t[0] = 1'b1;
      end
      r_t = rr[DIGIT_W-1:0];
    end
    w_next = w_t;
    r_next = r_t;
  end

  assign st.radix_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign st.negative   = neg;
  assign st.quot_zero  = (w_next == '0);
  assign st.last_digit = (count == CNT_W'(1));
  assign st.slot_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w <= PAD_BITS'(mag);
      r <= '0;
    end else if (cmd.div_step) begin
      w <= w_next;
      r <= cmd.div_last ? '0 : r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      neg   <= 1'b0;
    end else if (cmd.load) begin
      count <= '0;
      neg   <= raw[VALUE_BITS-1];
    end else if (cmd.div_last) begin
      count <= count + 1'b1;
    end else if (cmd.put_digit) begin
      count <= cnt_dec;
    end
  end

  // digit buffer, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (cmd.div_last) begin
      mem[count[IDX_W-1:0]] <= r_next;
    end
    if (cmd.rd) begin
      rd_data <= mem[cnt_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_sign || cmd.put_digit || cmd.put_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_empty) begin
      char_code <= CHAR_NONE;
      is_empty  <= 1'b1;
      is_final  <= 1'b1;
    end else if (cmd.put_sign) begin
      char_code <= CHAR_MINUS;
      is_empty  <= 1'b0;
      is_final  <= 1'b0;
    end else if (cmd.put_digit) begin
      char_code <= digit_char(rd_data);
      is_empty  <= 1'b0;
      is_final  <= st.last_digit;
    end
  end

endmodule

`default_nettype wire

[design/integer_to_base_string_unit.sv]
// integer to base string unit: one signed value in, its digits in radix 2..16 out
// the first character is the minus sign for a negative value, else the leading digit;
// all digits come from the shared radix divider and are sent most significant first.
// one value at a time: in_ready stays low until its last character is loaded;
// an invalid radix yields an empty character. output register holds the last one
// reset: synchronous, clears the state machine and output valid, radix back to 10
`default_nettype none

`include "assert_macros.svh"

module integer_to_base_string_unit #(
  parameter int VALUE_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire        [2:0]                  paddr,
  input  wire        [31:0]                 pwdata,
  output logic       [31:0]                 prdata,
  output logic                              pready,
  input  wire signed [VALUE_BITS-1:0]       value,
  input  wire                               in_valid,
  output logic                              in_ready,
  output logic       [itob_pkg::CHAR_W-1:0] char_code,
  output logic                              is_empty,
  output logic                              is_final,
  output logic                              out_valid,
  input  wire                               out_ready
);
  import itob_pkg::*;

  localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;

  logic [RADIX_W-1:0] radix;
  logic               reg_wr;
  itob_cmd_t          cmd;
  itob_stat_t         st;
  logic               put_any;
  logic               empty_out;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
  assign prdata = (paddr[2] == REG_RADIX) ? 32'(radix) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (reg_wr) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  itob_ctrl #(
    .DIV_CYCLES (DIV_CYCLES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  itob_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .radix     (radix),
    .st        (st),
    .char_code (char_code),
    .is_empty  (is_empty),
    .is_final  (is_final),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  assign put_any   = cmd.put_sign || cmd.put_digit || cmd.put_empty;
  assign empty_out = out_valid && is_empty;

  // a character is only loaded when the output register can take it
  `ITOB_ASSERT_SAME(a_put_needs_slot, clk, rst, put_any, st.slot_free)
  // one value in flight at a time
  `ITOB_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // an empty transaction is always the last and carries no character
  `ITOB_ASSERT_SAME(a_empty_is_final, clk, rst, empty_out, is_final && (char_code == CHAR_NONE))

endmodule

`default_nettype wire
